// ===== design/aes128_fi_pkg.sv =====
// AES-128 fault-injection package: word types, S-box, GF helpers.
// Used by aes128_fi_round and aes128_encrypt_fault_inject.
package aes128_fi_pkg;

	typedef enum logic [1:0] {
		STEP_KEY = 2'd0,
		STEP_SUB = 2'd1,
		STEP_ROW = 2'd2,
		STEP_MIX = 2'd3
	} step_t;

	// configuration register indexes
	localparam logic KEY_HIGH_IDX = 1'b0;
	localparam logic KEY_LOW_IDX  = 1'b1;

	localparam logic [3:0] LAST_ROUND = 4'd10;
	localparam logic [7:0] RCON_FIRST = 8'h01;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
		logic        fault_enable;
		logic [3:0]  fault_round;
		logic [1:0]  fault_step;
		logic        fault_after;
		logic [1:0]  fault_row;
		logic [1:0]  fault_column;
		logic [7:0]  fault_delta;
	} in_word_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} out_word_t;

	// fault selection carried down the pipeline
	typedef struct packed {
		logic       on;
		logic [3:0] round;
		logic [1:0] step;
		logic       after;
		logic [3:0] index;
		logic [7:0] delta;
	} fault_t;

	// state byte i sits in bits [127-8i -: 8]
	typedef logic [127:0] block_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// XOR delta into one state byte when the selection matches
	function automatic block_t inject(input block_t s, input fault_t f, input logic [3:0] round,
			input step_t step, input logic after);
		block_t r;
		r = s;
		if (f.on && f.round == round && f.step == step && f.after == after)
			r[127 - 8*f.index -: 8] = s[127 - 8*f.index -: 8] ^ f.delta;
		return r;
	endfunction

	function automatic block_t add_key(input block_t s, input block_t k);
		return s ^ k;
	endfunction

	function automatic block_t sub_bytes(input block_t s);
		block_t r;
		for (int i = 0; i < 16; i++)
			r[127 - 8*i -: 8] = SBOX[s[127 - 8*i -: 8]];
		return r;
	endfunction

	function automatic block_t shift_rows(input block_t s);
		block_t r;
		for (int c = 0; c < 4; c++)
			for (int w = 0; w < 4; w++)
				r[127 - 8*(c*4 + w) -: 8] = s[127 - 8*(((c + w) % 4)*4 + w) -: 8];
		return r;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t r;
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 8*(c*4)     -: 8];
			a1 = s[127 - 8*(c*4 + 1) -: 8];
			a2 = s[127 - 8*(c*4 + 2) -: 8];
			a3 = s[127 - 8*(c*4 + 3) -: 8];
			d0 = gf_double(a0);
			d1 = gf_double(a1);
			d2 = gf_double(a2);
			d3 = gf_double(a3);
			r[127 - 8*(c*4)     -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
			r[127 - 8*(c*4 + 1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
			r[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
			r[127 - 8*(c*4 + 3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
		end
		return r;
	endfunction

	function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
		block_t r;
		r = k;
		r[127 -: 8] = k[127 -: 8] ^ SBOX[k[23:16]] ^ rcon;
		r[119 -: 8] = k[119 -: 8] ^ SBOX[k[15:8]];
		r[111 -: 8] = k[111 -: 8] ^ SBOX[k[7:0]];
		r[103 -: 8] = k[103 -: 8] ^ SBOX[k[31:24]];
		for (int i = 4; i < 16; i++)
			r[127 - 8*i -: 8] = k[127 - 8*i -: 8] ^ r[127 - 8*(i - 4) -: 8];
		return r;
	endfunction

endpackage

// ===== design/aes128_fi_round.sv =====
// One AES round with fault taps: sub bytes, shift rows, mix columns, add key.
// Depends on aes128_fi_pkg.
module aes128_fi_round (
	input  logic [3:0]              round,
	input  aes128_fi_pkg::block_t   state_in,
	input  aes128_fi_pkg::block_t   key_in,
	input  logic [7:0]              rcon,
	input  aes128_fi_pkg::fault_t   fault,
	output aes128_fi_pkg::block_t   state_out,
	output aes128_fi_pkg::block_t   key_out
);
	import aes128_fi_pkg::*;

	block_t s0, s1, s2, s3;
	logic   last;

	assign last = (round == LAST_ROUND);
	assign key_out = next_key(key_in, rcon);

	// full round datapath, mix columns skipped in the last round
	always_comb begin
		s0 = inject(inject(sub_bytes(inject(state_in, fault, round, STEP_SUB, 1'b0)),
			fault, round, STEP_SUB, 1'b1), fault, round, STEP_ROW, 1'b0);
		s1 = inject(shift_rows(s0), fault, round, STEP_ROW, 1'b1);
		if (last) begin
			s2 = s1;
		end else begin
			s2 = inject(mix_columns(inject(s1, fault, round, STEP_MIX, 1'b0)),
				fault, round, STEP_MIX, 1'b1);
		end
		s3 = inject(add_key(inject(s2, fault, round, STEP_KEY, 1'b0), key_out),
			fault, round, STEP_KEY, 1'b1);
		state_out = s3;
	end

endmodule

// ===== design/aes128_encrypt_fault_inject.sv =====
// AES-128 encryption with single-byte fault injection, unrolled pipeline.
// Pipeline: 11 stages (initial key add, ten rounds); one word per cycle unless stalled.
// Each round is one stage of S-box, mix and key logic.
// A stall holds the whole pipeline; the output stage drains into a ready sink.
// Reset (arst_n low, asynchronous) clears stage valid bits and the key to zero.
module aes128_encrypt_fault_inject (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  aes128_fi_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output aes128_fi_pkg::out_word_t  out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [63:0]               cfg_data
);
	import aes128_fi_pkg::*;

	localparam int NSTAGE = 11;

	logic [63:0] key_high_q, key_low_q;
	logic        vld_q [NSTAGE];
	block_t      st_q  [NSTAGE];
	block_t      rk_q  [NSTAGE];
	logic [7:0]  rc_q  [NSTAGE];
	fault_t      flt_q [NSTAGE];
	logic        adv;
	fault_t      f_in;
	block_t      st_next [NSTAGE];
	block_t      rk_next [NSTAGE];

	assign cfg_ready = 1'b1;
	// pipeline moves when the last stage is empty or being taken
	assign adv = !vld_q[NSTAGE-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[NSTAGE-1];
	assign out_data.cipher_high = st_q[NSTAGE-1][127:64];
	assign out_data.cipher_low  = st_q[NSTAGE-1][63:0];

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
			KEY_HIGH_IDX: key_high_q <= cfg_data;
			KEY_LOW_IDX:  key_low_q  <= cfg_data;
			endcase
		end
	end

	assign f_in.on    = in_data.fault_enable;
	assign f_in.round = in_data.fault_round;
	assign f_in.step  = in_data.fault_step;
	assign f_in.after = in_data.fault_after;
	assign f_in.index = {in_data.fault_column, in_data.fault_row};
	assign f_in.delta = in_data.fault_delta;

	// round 0: add round key only
	assign st_next[0] = inject(add_key(inject({in_data.plain_high, in_data.plain_low}, f_in,
		4'd0, STEP_KEY, 1'b0), {key_high_q, key_low_q}), f_in, 4'd0, STEP_KEY, 1'b1);
	assign rk_next[0] = {key_high_q, key_low_q};

	// rounds 1 to 10
	for (genvar g = 1; g < NSTAGE; g++) begin : g_round
		aes128_fi_round u_round (
			.round     (4'(g)),
			.state_in  (st_q[g-1]),
			.key_in    (rk_q[g-1]),
			.rcon      (rc_q[g-1]),
			.fault     (flt_q[g-1]),
			.state_out (st_next[g]),
			.key_out   (rk_next[g])
		);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTAGE; i++) vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < NSTAGE; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0]  <= st_next[0];
			rk_q[0]  <= rk_next[0];
			rc_q[0]  <= RCON_FIRST;
			flt_q[0] <= f_in;
			for (int i = 1; i < NSTAGE; i++) begin
				st_q[i]  <= st_next[i];
				rk_q[i]  <= rk_next[i];
				rc_q[i]  <= gf_double(rc_q[i-1]);
				flt_q[i] <= flt_q[i-1];
			end
		end
	end

endmodule

// ===== bench/aes128_fi_checker.sv =====
`timescale 1ns / 1ps
// Cipher checker for aes128_encrypt_fault_inject: tracks key writes, predicts each
// ciphertext word with fault injection, compares against the output channel.
// Depends on aes128_fi_pkg for the word types and step codes.
module aes128_fi_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  aes128_fi_pkg::in_word_t  in_data,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  aes128_fi_pkg::out_word_t out_data,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [63:0]              cfg_data,
	output int                       fail_count,
	output int                       pending
);
	import aes128_fi_pkg::*;

	logic [63:0] key_hi, key_lo;
	out_word_t   cipher_q[$];
	byte unsigned sb[256];

	initial begin
		for (int i = 0; i < 256; i++) sb[i] = SBOX[i];
	end

	function automatic byte unsigned xt(byte unsigned a);
		return byte'({a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00));
	endfunction

	// ciphertext for one plaintext word under the current key
	function automatic out_word_t encrypt_word(in_word_t w);
		byte unsigned st[16], rk[16], t[16];
		byte unsigned rc, a0, a1, a2, a3;
		step_t seq[4];
		int idx, first, last;
		out_word_t o;
		rc = 8'h01;
		idx = w.fault_column * 4 + w.fault_row;
		for (int i = 0; i < 8; i++) begin
			st[i]     = w.plain_high[63 - 8*i -: 8];
			st[i + 8] = w.plain_low[63 - 8*i -: 8];
			rk[i]     = key_hi[63 - 8*i -: 8];
			rk[i + 8] = key_lo[63 - 8*i -: 8];
		end
		seq = '{STEP_SUB, STEP_ROW, STEP_MIX, STEP_KEY};
		for (int rnd = 0; rnd <= 10; rnd++) begin
			first = (rnd == 0) ? 3 : 0;
			for (int k = first; k < 4; k++) begin
				if (rnd == 10 && seq[k] == STEP_MIX) continue;
				for (int aft = 0; aft < 2; aft++) begin
					if (aft == 1) begin
						// apply the step between the before and after hooks
						case (seq[k])
						STEP_KEY: begin
							if (rnd > 0) begin
								rk[0] ^= sb[rk[13]] ^ rc;
								rk[1] ^= sb[rk[14]];
								rk[2] ^= sb[rk[15]];
								rk[3] ^= sb[rk[12]];
								for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
								rc = xt(rc);
							end
							for (int i = 0; i < 16; i++) st[i] ^= rk[i];
						end
						STEP_SUB: for (int i = 0; i < 16; i++) st[i] = sb[st[i]];
						STEP_ROW: begin
							for (int c = 0; c < 4; c++)
								for (int r = 0; r < 4; r++)
									t[c*4 + r] = st[((c + r) % 4)*4 + r];
							st = t;
						end
						default: for (int c = 0; c < 4; c++) begin
							a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
							st[c*4]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
							st[c*4+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
							st[c*4+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
							st[c*4+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
						end
						endcase
					end
					if (w.fault_enable && w.fault_round == rnd && w.fault_step == seq[k]
							&& w.fault_after == aft)
						st[idx] ^= w.fault_delta;
				end
			end
		end
		for (int i = 0; i < 8; i++) begin
			o.cipher_high[63 - 8*i -: 8] = st[i];
			o.cipher_low[63 - 8*i -: 8]  = st[i + 8];
		end
		return o;
	endfunction

	assign pending = cipher_q.size();

	// key writes, input words and output words at the rising edge
	always @(posedge clk or negedge arst_n) begin : p_check
		int errs;
		out_word_t e;
		errs = 0;
		if (!arst_n) begin
			key_hi <= '0;
			key_lo <= '0;
			fail_count <= 0;
			cipher_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == KEY_HIGH_IDX) key_hi <= cfg_data;
				else if (cfg_index == KEY_LOW_IDX) key_lo <= cfg_data;
			end
			if (in_valid && in_ready) cipher_q.push_back(encrypt_word(in_data));
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected cipher word %h", out_data);
					errs++;
				end else begin
					e = cipher_q.pop_front();
					if (e.cipher_high !== out_data.cipher_high) begin
						$error("cipher_high expected %h got %h", e.cipher_high,
							out_data.cipher_high);
						errs++;
					end
					if (e.cipher_low !== out_data.cipher_low) begin
						$error("cipher_low expected %h got %h", e.cipher_low,
							out_data.cipher_low);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== bench/tb_aes128_encrypt_fault_inject.sv =====
`timescale 1ns / 1ps
// Stimulus top for aes128_encrypt_fault_inject: key phases, directed and random
// fault words, idling phases and a long output hold-off. Uses aes128_fi_checker.
module tb_aes128_encrypt_fault_inject;
	import aes128_fi_pkg::*;

	localparam int   WATCHDOG = 20000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [63:0] cfg_data;
	in_word_t  in_data;
	out_word_t out_data;
	int fail_count, pending;
	int send_idle, recv_stall, hold_off, idle_cycles;

	aes128_encrypt_fault_inject dut (.*);
	aes128_fi_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("aes128_encrypt_fault_inject verification failed");
			$finish;
		end
	end

	// output side: random stalls plus an optional long hold-off
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 0;
			end else out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_key(logic idx, logic [63:0] v);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// called at a falling edge right after the last accepted word
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic in_word_t rand_word(bit aimed);
		in_word_t w;
		logic [159:0] rnd_bits;
		rnd_bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = rnd_bits[$bits(in_word_t)-1:0];
		if (aimed) begin
			w.fault_enable = ($urandom_range(9) != 0);
			w.fault_round = 4'($urandom_range(10));
		end else w.fault_round = 4'($urandom_range(15));
		return w;
	endfunction

	initial begin
		in_word_t w;
		logic [63:0] keys[4][2];
		arst_n = 0; in_valid = 0; in_data = '0;
		cfg_valid = 0; cfg_index = KEY_HIGH_IDX; cfg_data = '0;
		send_idle = 0; recv_stall = 0; hold_off = 0; idle_cycles = 0;
		keys = '{'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c},
			'{64'hffffffffffffffff, 64'hffffffffffffffff},
			'{64'h0, 64'h0},
			'{{$urandom, $urandom}, {$urandom, $urandom}}};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: known vector, all-ones plain, each step (hooks alternating), edge rounds
		w = '0;
		w.plain_high = 64'h3243f6a8885a308d; w.plain_low = 64'h313198a2e0370734;
		send_word(w);
		drain();
		write_key(KEY_HIGH_IDX, keys[0][0]);
		write_key(KEY_LOW_IDX, keys[0][1]);
		send_word(w);
		w.plain_high = '1; w.plain_low = '1; send_word(w);
		for (int r = 0; r < 16; r += 5)
			for (int s = 0; s < 4; s++) begin
				w = rand_word(0);
				w.fault_enable = 1; w.fault_round = (r == 15) ? 4'd10 : 4'(r);
				w.fault_step = s[1:0]; w.fault_after = s[0];
				w.fault_delta = (s == 2) ? 8'h00 : 8'hff;
				send_word(w);
			end
		w.fault_round = 4'd15; w.fault_enable = 1; send_word(w);
		w.fault_enable = 0; w.fault_round = 4'd3; send_word(w);
		drain();

		// random phases over several keys and idling patterns
		for (int ph = 0; ph < 4; ph++) begin
			write_key(KEY_HIGH_IDX, keys[ph][0]);
			write_key(KEY_LOW_IDX, keys[ph][1]);
			case (ph)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 80; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 80; end
			default: begin send_idle = 13; recv_stall = 13; end
			endcase
			if (ph == 0) hold_off = 300;
			for (int i = 0; i < 500; i++) send_word(rand_word($urandom_range(9) != 0));
			drain();
		end

		if (fail_count == 0)
			$display("aes128_encrypt_fault_inject verification clean");
		else
			$display("aes128_encrypt_fault_inject verification failed");
		$finish;
	end
endmodule
